// ===== rtl/bws_pkg.sv =====
// Shared constants, codes and helper functions of the bilinear wrap texel sampler.
// Used by rtl/bilinear_wrap_texel_sampler.sv; depends on nothing else.

package bws_pkg;

  // Fixed field widths
  localparam int COORD_W   = 18;
  localparam int CHAN_W    = 8;
  localparam int TEXEL_W   = 3 * CHAN_W;
  localparam int SIDE_W    = 7;
  localparam int REG_IDX_W = 1;
  localparam int IN_DATA_W = 64;
  localparam int OUT_DATA_W = 24;

  // Defaults of the top level parameters
  localparam int MAX_SIDE_DEF      = 64;
  localparam int FRACTION_BITS_DEF = 8;

  // Side register reset value before clamping
  localparam int SIDE_RESET = 64;

  // Operation codes carried in tuser
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  // One restoring remainder step: shift in one bit, subtract side once if reached.
  // The running remainder stays below side, so one subtract suffices.
  function automatic logic [SIDE_W-1:0] rem_step(input logic [SIDE_W-1:0] r,
                                                 input logic              b,
                                                 input logic [SIDE_W-1:0] side);
    logic [SIDE_W:0] t;
    t = {r, b};
    if (t >= {1'b0, side}) begin
      t = t - {1'b0, side};
    end
    return t[SIDE_W-1:0];
  endfunction

  // Pick one 8-bit channel of a texel: 0 red, 1 green, 2 blue
  function automatic logic [CHAN_W-1:0] chan_of(input logic [TEXEL_W-1:0] t,
                                                input logic [1:0]         ch);
    logic [CHAN_W-1:0] c;
    case (ch)
      2'd0:    c = t[3*CHAN_W-1:2*CHAN_W];
      2'd1:    c = t[2*CHAN_W-1:CHAN_W];
      default: c = t[CHAN_W-1:0];
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/bilinear_wrap_texel_sampler.sv =====
// Pipelined bilinear texel sampler with wrap addressing and a replicated texel store.
// Depends on rtl/bws_pkg.sv for widths, codes and the remainder step.

// Usage
//   Input stream s_*: s_tuser is the operation (0 write texel, 1 sample);
//   s_tdata carries coord_x, coord_y (unsigned, FRACTION_BITS fraction bits)
//   and the texel to write. Output stream m_*: one blended RGB result for
//   each sample, none for a write (writes outside the size in use are dropped).
//   cfg_we/cfg_index/cfg_data set the width and height in use (0 acts as 1,
//   values above MAX_SIDE act as MAX_SIDE); write them only while idle.
// Throughput and pipeline
//   One item per cycle while the output is not stalled. After the input
//   register, the wrap remainder takes two bits per stage, then neighbor
//   select, texel read, weight products and the channel sums each take one
//   stage.
//   Four copies of the texel store give the four neighbor reads in the same cycle.
// Reset and stall
//   Reset empties the pipeline and sets both sizes to 64 (clamped to
//   MAX_SIDE); texels are undefined until written. A stalled output holds its
//   result while bubbles ahead of it keep being filled, so s_tready stays
//   high until every stage holds an item.

module bilinear_wrap_texel_sampler #(
  parameter int MAX_SIDE      = bws_pkg::MAX_SIDE_DEF,
  parameter int FRACTION_BITS = bws_pkg::FRACTION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration write port
  input  logic                             cfg_we,
  input  logic [bws_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [bws_pkg::SIDE_W-1:0]       cfg_data,
  // Input stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // coord_x[17:0], coord_y[35:18], write_red[43:36], write_green[51:44],
  // write_blue[59:52], zero fill[63:60]
  input  logic [bws_pkg::IN_DATA_W-1:0]    s_tdata,
  // operation[0]
  input  logic                             s_tuser,
  // Output stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // sample_red[7:0], sample_green[15:8], sample_blue[23:16]
  output logic [bws_pkg::OUT_DATA_W-1:0]   m_tdata
);

  localparam int SW   = bws_pkg::SIDE_W;
  localparam int CW   = bws_pkg::CHAN_W;
  localparam int TW   = bws_pkg::TEXEL_W;
  localparam int FB   = FRACTION_BITS;
  localparam int IW   = bws_pkg::COORD_W - FB;
  localparam int K    = (IW + 1) / 2;
  localparam int PW   = 2 * K;
  localparam int LOGS = $clog2(MAX_SIDE);
  localparam int AW   = (LOGS < SW) ? LOGS : SW;
  localparam int MADW = 2 * AW;
  localparam int DEPTH = 1 << MADW;
  localparam int WW   = 2 * FB + 1;
  localparam int PRW  = WW + CW;
  localparam int SUMW = PRW + 2;
  // Stage numbers
  localparam int ST_NB  = K + 1;
  localparam int ST_MEM = K + 2;
  localparam int ST_PRD = K + 3;
  localparam int ST_OUT = K + 4;
  localparam int NST    = K + 5;
  localparam int CAP_I  = (MAX_SIDE > 127) ? 127 : MAX_SIDE;
  localparam logic [SW-1:0] SIDE_CAP   = SW'(CAP_I);
  localparam logic [SW-1:0] RESET_SIDE =
      SW'((bws_pkg::SIDE_RESET > CAP_I) ? CAP_I : bws_pkg::SIDE_RESET);
  localparam logic [FB:0] ONE = (FB + 1)'(1) << FB;

  // Configuration registers
  logic [SW-1:0] width_in_use;
  logic [SW-1:0] height_in_use;
  logic [SW-1:0] cfg_side;

  // Clamp the written size into the legal range
  always_comb begin
    if (cfg_data == '0) begin
      cfg_side = SW'(1);
    end else if (cfg_data > SIDE_CAP) begin
      cfg_side = SIDE_CAP;
    end else begin
      cfg_side = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_use  <= RESET_SIDE;
      height_in_use <= RESET_SIDE;
    end else if (cfg_we) begin
      case (cfg_index)
        bws_pkg::REG_WIDTH:  width_in_use  <= cfg_side;
        bws_pkg::REG_HEIGHT: height_in_use <= cfg_side;
        default: ;
      endcase
    end
  end

  // Stage valids and per-stage advance
  logic [NST-1:0] v;
  logic [NST:0]   en;

  // A stage loads when empty or when the stage after it moves on
  always_comb begin
    en[NST] = m_tready;
    for (int i = NST - 1; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = v[ST_OUT];

  // Input field split
  logic [IW-1:0] ix_in;
  logic [IW-1:0] iy_in;
  assign ix_in = s_tdata[bws_pkg::COORD_W-1:FB];
  assign iy_in = s_tdata[2*bws_pkg::COORD_W-1:bws_pkg::COORD_W+FB];

  // Remainder pipeline: index 0 is the input register
  logic          d_op  [K+1];
  logic          d_wok [K+1];
  logic [PW-1:0] d_xs  [K+1];
  logic [PW-1:0] d_ys  [K+1];
  logic [SW-1:0] d_rx  [K+1];
  logic [SW-1:0] d_ry  [K+1];
  logic [FB-1:0] d_fx  [K+1];
  logic [FB-1:0] d_fy  [K+1];
  logic [TW-1:0] d_rgb [K+1];

  // Neighbor stage registers
  logic          nb_op;
  logic          nb_wok;
  logic [SW-1:0] nb_x1, nb_x2, nb_y1, nb_y2;
  logic [FB-1:0] nb_fx, nb_fy;
  logic [TW-1:0] nb_rgb;

  // Valid bits travel with the items; writes end at the memory stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (en[i]) begin
          if (i == 0) begin
            v[i] <= s_tvalid;
          end else if (i == ST_MEM) begin
            v[i] <= v[i-1] && (nb_op == bws_pkg::OP_SAMPLE);
          end else begin
            v[i] <= v[i-1];
          end
        end
      end
    end
  end

  // Capture the input item and its write bound check
  always_ff @(posedge clk) begin
    if (en[0]) begin
      d_op[0]  <= s_tuser;
      d_wok[0] <= (ix_in < width_in_use) && (iy_in < height_in_use);
      d_xs[0]  <= PW'(ix_in);
      d_ys[0]  <= PW'(iy_in);
      d_rx[0]  <= '0;
      d_ry[0]  <= '0;
      d_fx[0]  <= s_tdata[FB-1:0];
      d_fy[0]  <= s_tdata[bws_pkg::COORD_W+FB-1:bws_pkg::COORD_W];
      d_rgb[0] <= {s_tdata[43:36], s_tdata[51:44], s_tdata[59:52]};
    end
  end

  // Wrap remainder, two integer bits per stage, most significant first.
  // For an in-range write the remainders equal the write address.
  for (genvar k = 1; k <= K; k++) begin : g_rem
    always_ff @(posedge clk) begin
      if (en[k]) begin
        d_op[k]  <= d_op[k-1];
        d_wok[k] <= d_wok[k-1];
        d_xs[k]  <= d_xs[k-1] << 2;
        d_ys[k]  <= d_ys[k-1] << 2;
        d_rx[k]  <= bws_pkg::rem_step(
                      bws_pkg::rem_step(d_rx[k-1], d_xs[k-1][PW-1], width_in_use),
                      d_xs[k-1][PW-2], width_in_use);
        d_ry[k]  <= bws_pkg::rem_step(
                      bws_pkg::rem_step(d_ry[k-1], d_ys[k-1][PW-1], height_in_use),
                      d_ys[k-1][PW-2], height_in_use);
        d_fx[k]  <= d_fx[k-1];
        d_fy[k]  <= d_fy[k-1];
        d_rgb[k] <= d_rgb[k-1];
      end
    end
  end

  // Neighbor stage: one step lower in each axis, with wrap
  always_ff @(posedge clk) begin
    if (en[ST_NB]) begin
      nb_op  <= d_op[K];
      nb_wok <= d_wok[K];
      nb_x1  <= d_rx[K];
      nb_y1  <= d_ry[K];
      nb_x2  <= (d_rx[K] == '0) ? width_in_use - SW'(1) : d_rx[K] - SW'(1);
      nb_y2  <= (d_ry[K] == '0) ? height_in_use - SW'(1) : d_ry[K] - SW'(1);
      nb_fx  <= d_fx[K];
      nb_fy  <= d_fy[K];
      nb_rgb <= d_rgb[K];
    end
  end

  // Memory stage: four store copies, one read port each; writes hit all four
  logic [MADW-1:0] rd_addr [4];
  logic [MADW-1:0] wr_addr;
  logic            wr_en;
  logic [TW-1:0]   tex     [4];

  assign rd_addr[0] = {nb_y1[AW-1:0], nb_x1[AW-1:0]};
  assign rd_addr[1] = {nb_y2[AW-1:0], nb_x1[AW-1:0]};
  assign rd_addr[2] = {nb_y1[AW-1:0], nb_x2[AW-1:0]};
  assign rd_addr[3] = {nb_y2[AW-1:0], nb_x2[AW-1:0]};
  assign wr_addr    = {nb_y1[AW-1:0], nb_x1[AW-1:0]};
  assign wr_en      = en[ST_MEM] && v[ST_NB] && (nb_op == bws_pkg::OP_WRITE) && nb_wok;

  for (genvar m = 0; m < 4; m++) begin : g_store
    logic [TW-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[wr_addr] <= nb_rgb;
      end
    end

    always_ff @(posedge clk) begin
      if (en[ST_MEM]) begin
        tex[m] <= mem[rd_addr[m]];
      end
    end
  end

  // Corner weights, registered beside the texel reads
  logic [FB:0]   fx_c, fy_c;
  logic [WW-1:0] wgt [4];

  assign fx_c = ONE - {1'b0, nb_fx};
  assign fy_c = ONE - {1'b0, nb_fy};

  always_ff @(posedge clk) begin
    if (en[ST_MEM]) begin
      wgt[0] <= WW'({1'b0, nb_fx} * {1'b0, nb_fy});
      wgt[1] <= WW'({1'b0, nb_fx} * fy_c);
      wgt[2] <= WW'(fx_c * {1'b0, nb_fy});
      wgt[3] <= WW'(fx_c * fy_c);
    end
  end

  // Product stage: weight times channel for each corner
  logic [PRW-1:0] prod [3][4];

  always_ff @(posedge clk) begin
    if (en[ST_PRD]) begin
      for (int c = 0; c < 3; c++) begin
        for (int m = 0; m < 4; m++) begin
          prod[c][m] <= PRW'(wgt[m] * bws_pkg::chan_of(tex[m], 2'(c)));
        end
      end
    end
  end

  // Output stage: sum the corners and drop the weight fraction
  logic [SUMW-1:0] sum [3];
  logic [CW-1:0]   res [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = SUMW'(prod[c][0]) + SUMW'(prod[c][1])
             + SUMW'(prod[c][2]) + SUMW'(prod[c][3]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      for (int c = 0; c < 3; c++) begin
        res[c] <= sum[c][2*FB+CW-1:2*FB];
      end
    end
  end

  assign m_tdata = {res[2], res[1], res[0]};

endmodule
